// File: src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared widths, types and register codes for the 4x4 matrix-vector transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int ROWS       = 4;
  localparam int COLS       = 4;
  localparam int COEFF_W    = 16;
  localparam int VEC_W      = 32;
  localparam int COEFF_FRAC = 12;
  localparam int CFG_W      = COLS * COEFF_W;
  localparam int CFG_IDX_W  = 4;

  localparam int PROD_W  = COEFF_W + VEC_W;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SHIFT_W = SUM_W - COEFF_FRAC;

  typedef logic [CFG_W-1:0]  row_t;
  typedef row_t [ROWS-1:0]   matrix_t;
  typedef logic [VEC_W-1:0]  comp_t;
  typedef comp_t [COLS-1:0]  vec_t;
  typedef comp_t [ROWS-1:0]  res_t;

  typedef logic [PROD_W-1:0] prod_t;
  typedef prod_t [COLS-1:0]  prod_row_t;
  typedef prod_row_t [ROWS-1:0] prod_mat_t;

  typedef logic [PAIR_W-1:0] pair_t;
  typedef pair_t [1:0]       pair_row_t;
  typedef pair_row_t [ROWS-1:0] pair_mat_t;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef sum_t [ROWS-1:0]   sum_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_ROW3
  } reg_idx_t;

  localparam row_t ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam row_t ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam row_t ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam row_t ROW3_RESET = 64'h1000_0000_0000_0000;

  localparam comp_t VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam comp_t VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

// File: src/mvt_mul.sv
// ----------------------------------------------------------------------------
// mvt_mul
// First stage: sixteen coefficient by component products, registered.
// ----------------------------------------------------------------------------
module mvt_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mvt_pkg::vec_t       vec,
  input  mvt_pkg::matrix_t    coeffs,
  output logic                out_valid,
  input  logic                out_ready,
  output mvt_pkg::prod_mat_t  prod
);
  import mvt_pkg::*;

  prod_mat_t prod_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        prod_next[r][c] = $signed(coeffs[r][c*COEFF_W +: COEFF_W]) * $signed(vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
  end

endmodule

// File: src/mvt_add.sv
// ----------------------------------------------------------------------------
// mvt_add
// Two registered adder levels that reduce each row's products to one sum.
// ----------------------------------------------------------------------------
module mvt_add (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mvt_pkg::prod_mat_t  prod,
  output logic                out_valid,
  input  logic                out_ready,
  output mvt_pkg::sum_vec_t   sum
);
  import mvt_pkg::*;

  pair_mat_t pair;
  pair_mat_t pair_next;
  sum_vec_t  sum_next;
  logic      pair_valid;
  logic      pair_ready;

  assign pair_ready = !out_valid || out_ready;
  assign in_ready   = !pair_valid || pair_ready;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < 2; k++) begin
        pair_next[r][k] = $signed(prod[r][2*k]) + $signed(prod[r][2*k+1]);
      end
      sum_next[r] = $signed(pair[r][0]) + $signed(pair[r][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_valid <= in_valid;
      end
      if (pair_ready) begin
        out_valid <= pair_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pair <= pair_next;
    end
    if (pair_ready && pair_valid) begin
      sum <= sum_next;
    end
  end

endmodule

// File: src/mvt_sat.sv
// ----------------------------------------------------------------------------
// mvt_sat
// Output stage: drops the fraction bits, clamps to 32 bits, holds the word.
// ----------------------------------------------------------------------------
module mvt_sat (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mvt_pkg::sum_vec_t  sum,
  output logic               out_valid,
  input  logic               out_ready,
  output mvt_pkg::res_t      res,
  output logic               sat
);
  import mvt_pkg::*;

  res_t        res_next;
  logic [ROWS-1:0] clamp;
  logic [SHIFT_W-1:0] q [ROWS];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      q[r] = sum[r][SUM_W-1:COEFF_FRAC];
      clamp[r] = !((&q[r][SHIFT_W-1:VEC_W-1]) || !(|q[r][SHIFT_W-1:VEC_W-1]));
      if (clamp[r]) begin
        res_next[r] = q[r][SHIFT_W-1] ? VEC_MIN : VEC_MAX;
      end else begin
        res_next[r] = q[r][VEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
      sat <= |clamp;
    end
  end

endmodule

// File: src/mat4_vec4_transform_top.sv
// ----------------------------------------------------------------------------
// mat4_vec4_transform_top
// 4x4 matrix of Q3.12 coefficients times a Q16.16 vector, saturated result.
//
//   channel  handshake            payload
//   config   cfg_we               cfg_index, cfg_data (row r, column j at 16j)
//   input    in_valid / in_stall  in_x, in_y, in_z, in_w
//   output   out_valid / out_stall out_x, out_y, out_z, out_w, saturated
//
// one word per cycle sustained while out_stall is low; registered stages are
// multiply, two adder levels, clamp and output register
// reset empties the pipeline and loads the identity matrix
// a stall holds every full stage with no empty stage below it; in_stall rises
// only when all four stages are full and the output word is stalled
// ----------------------------------------------------------------------------
module mat4_vec4_transform_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mvt_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mvt_pkg::VEC_W-1:0]    in_x,
  input  logic signed [mvt_pkg::VEC_W-1:0]    in_y,
  input  logic signed [mvt_pkg::VEC_W-1:0]    in_z,
  input  logic signed [mvt_pkg::VEC_W-1:0]    in_w,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mvt_pkg::VEC_W-1:0]    out_x,
  output logic signed [mvt_pkg::VEC_W-1:0]    out_y,
  output logic signed [mvt_pkg::VEC_W-1:0]    out_z,
  output logic signed [mvt_pkg::VEC_W-1:0]    out_w,
  output logic                                saturated
);
  import mvt_pkg::*;

  matrix_t   coeffs;
  vec_t      vec;
  prod_mat_t prod;
  sum_vec_t  sum;
  res_t      res;
  logic      in_ready;
  logic      mul_valid;
  logic      mul_ready;
  logic      add_valid;
  logic      add_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs[0] <= ROW0_RESET;
      coeffs[1] <= ROW1_RESET;
      coeffs[2] <= ROW2_RESET;
      coeffs[3] <= ROW3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0: coeffs[0] <= cfg_data;
        REG_ROW1: coeffs[1] <= cfg_data;
        REG_ROW2: coeffs[2] <= cfg_data;
        REG_ROW3: coeffs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vec[0]   = in_x;
  assign vec[1]   = in_y;
  assign vec[2]   = in_z;
  assign vec[3]   = in_w;
  assign in_stall = !in_ready;

  mvt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vec       (vec),
    .coeffs    (coeffs),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .prod      (prod)
  );

  mvt_add u_add (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .prod      (prod),
    .out_valid (add_valid),
    .out_ready (add_ready),
    .sum       (sum)
  );

  mvt_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (add_valid),
    .in_ready  (add_ready),
    .sum       (sum),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .res       (res),
    .sat       (saturated)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

// File: src/mvt_checker.sv
// ----------------------------------------------------------------------------
// mvt_checker
// Port-level checks on the transform pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module mvt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [mvt_pkg::VEC_W-1:0]  out_x,
  input logic signed [mvt_pkg::VEC_W-1:0]  out_y,
  input logic signed [mvt_pkg::VEC_W-1:0]  out_z,
  input logic signed [mvt_pkg::VEC_W-1:0]  out_w,
  input logic                              saturated
);
  import mvt_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_w) && $stable(saturated))
    else $error("stalled output word changed");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // input back-pressure only when the output word is valid and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // the flag means some component sits at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      out_x == VEC_MAX || out_x == VEC_MIN || out_y == VEC_MAX || out_y == VEC_MIN ||
      out_z == VEC_MAX || out_z == VEC_MIN || out_w == VEC_MAX || out_w == VEC_MIN)
    else $error("saturation flag without a clamped component");

endmodule

bind mat4_vec4_transform_top mvt_checker u_chk (.*);
